FILE: sv/itd_pkg.sv
// Shared types, beat structs, controller/datapath interface and the key ROM
// for the transliteration block. No dependencies.
`default_nettype none

package itd_pkg;

  // Number of entries in the key ROM.
  localparam int ROM_SIZE = 153;

  // One input beat.
  typedef struct packed {
    logic [7:0] in_char;
    logic       string_end;
  } in_beat_t;

  // One output beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // accept an input beat into the window
    logic start;   // begin a match at the longest available length
    logic search;  // try one key length
    logic emit;    // send one output byte
  } itd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go;          // window needs another match
    logic found;       // search resolved (hit or single-byte pass-through)
    logic slot_free;   // output register can take a byte
    logic match_last;  // current byte is the last one of the match
  } itd_stat_t;

  // Key ROM entry. The key is right-justified, first character in the
  // highest used byte.
  typedef struct packed {
    logic [31:0] key;
    logic [2:0]  klen;
    logic [1:0]  ncodes;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] c2;
  } rom_entry_t;

  function automatic rom_entry_t mk(input logic [31:0] k, input logic [2:0] l,
                                    input logic [1:0] n, input logic [15:0] a,
                                    input logic [15:0] b, input logic [15:0] c);
    rom_entry_t e;
    e.key    = k;
    e.klen   = l;
    e.ncodes = n;
    e.c0     = a;
    e.c1     = b;
    e.c2     = c;
    return e;
  endfunction

  // Key ROM in table order; earlier entries win on duplicate keys.
  function automatic rom_entry_t rom_get(input logic [7:0] idx);
    rom_entry_t e;
    case (idx)
      8'd0:   e = mk("a",    3'd1, 2'd1, 16'h0905, 16'h0, 16'h0);
      8'd1:   e = mk("A",    3'd1, 2'd1, 16'h0906, 16'h0, 16'h0);
      8'd2:   e = mk("aa",   3'd2, 2'd1, 16'h0906, 16'h0, 16'h0);
      8'd3:   e = mk("iI",   3'd2, 2'd1, 16'h0907, 16'h0, 16'h0);
      8'd4:   e = mk("II",   3'd2, 2'd1, 16'h0908, 16'h0, 16'h0);
      8'd5:   e = mk("iiI",  3'd3, 2'd1, 16'h0908, 16'h0, 16'h0);
      8'd6:   e = mk("ee",   3'd2, 2'd1, 16'h0908, 16'h0, 16'h0);
      8'd7:   e = mk("u",    3'd1, 2'd1, 16'h0909, 16'h0, 16'h0);
      8'd8:   e = mk("U",    3'd1, 2'd1, 16'h090A, 16'h0, 16'h0);
      8'd9:   e = mk("uu",   3'd2, 2'd1, 16'h090A, 16'h0, 16'h0);
      8'd10:  e = mk("RRi",  3'd3, 2'd1, 16'h090B, 16'h0, 16'h0);
      8'd11:  e = mk("R^i",  3'd3, 2'd1, 16'h090B, 16'h0, 16'h0);
      8'd12:  e = mk("RRI",  3'd3, 2'd1, 16'h0960, 16'h0, 16'h0);
      8'd13:  e = mk("R^I",  3'd3, 2'd1, 16'h0960, 16'h0, 16'h0);
      8'd14:  e = mk("LLi",  3'd3, 2'd1, 16'h090C, 16'h0, 16'h0);
      8'd15:  e = mk("L^i",  3'd3, 2'd1, 16'h090C, 16'h0, 16'h0);
      8'd16:  e = mk("LLI",  3'd3, 2'd1, 16'h0961, 16'h0, 16'h0);
      8'd17:  e = mk("L^I",  3'd3, 2'd1, 16'h0961, 16'h0, 16'h0);
      8'd18:  e = mk("^e",   3'd2, 2'd1, 16'h090E, 16'h0, 16'h0);
      8'd19:  e = mk("e",    3'd1, 2'd1, 16'h090F, 16'h0, 16'h0);
      8'd20:  e = mk("E",    3'd1, 2'd1, 16'h090F, 16'h0, 16'h0);
      8'd21:  e = mk("ae",   3'd2, 2'd1, 16'h090D, 16'h0, 16'h0);
      8'd22:  e = mk("aE",   3'd2, 2'd1, 16'h090D, 16'h0, 16'h0);
      8'd23:  e = mk("ai",   3'd2, 2'd1, 16'h0910, 16'h0, 16'h0);
      8'd24:  e = mk("^o",   3'd2, 2'd1, 16'h0912, 16'h0, 16'h0);
      8'd25:  e = mk("o",    3'd1, 2'd1, 16'h0913, 16'h0, 16'h0);
      8'd26:  e = mk("O",    3'd1, 2'd1, 16'h0913, 16'h0, 16'h0);
      8'd27:  e = mk("au",   3'd2, 2'd1, 16'h0914, 16'h0, 16'h0);
      8'd28:  e = mk("aU",   3'd2, 2'd1, 16'h0972, 16'h0, 16'h0);
      8'd29:  e = mk("AU",   3'd2, 2'd1, 16'h0911, 16'h0, 16'h0);
      8'd30:  e = mk(".a",   3'd2, 2'd1, 16'h093D, 16'h0, 16'h0);
      8'd31:  e = mk("OM",   3'd2, 2'd1, 16'h0950, 16'h0, 16'h0);
      8'd32:  e = mk("AUM",  3'd3, 2'd1, 16'h0950, 16'h0, 16'h0);
      8'd33:  e = mk("ka",   3'd2, 2'd1, 16'h0915, 16'h0, 16'h0);
      8'd34:  e = mk("k",    3'd1, 2'd1, 16'h0915, 16'h0, 16'h0);
      8'd35:  e = mk("kha",  3'd3, 2'd1, 16'h0916, 16'h0, 16'h0);
      8'd36:  e = mk("kh",   3'd2, 2'd1, 16'h0916, 16'h0, 16'h0);
      8'd37:  e = mk("ga",   3'd2, 2'd1, 16'h0917, 16'h0, 16'h0);
      8'd38:  e = mk("g",    3'd1, 2'd1, 16'h0917, 16'h0, 16'h0);
      8'd39:  e = mk("gha",  3'd3, 2'd1, 16'h0918, 16'h0, 16'h0);
      8'd40:  e = mk("gh",   3'd2, 2'd1, 16'h0918, 16'h0, 16'h0);
      8'd41:  e = mk("~Na",  3'd3, 2'd1, 16'h0919, 16'h0, 16'h0);
      8'd42:  e = mk("~N",   3'd2, 2'd1, 16'h0919, 16'h0, 16'h0);
      8'd43:  e = mk("cha",  3'd3, 2'd1, 16'h091A, 16'h0, 16'h0);
      8'd44:  e = mk("ch",   3'd2, 2'd1, 16'h091A, 16'h0, 16'h0);
      8'd45:  e = mk("Cha",  3'd3, 2'd1, 16'h091B, 16'h0, 16'h0);
      8'd46:  e = mk("Ch",   3'd2, 2'd1, 16'h091B, 16'h0, 16'h0);
      8'd47:  e = mk("ja",   3'd2, 2'd1, 16'h091C, 16'h0, 16'h0);
      8'd48:  e = mk("j",    3'd1, 2'd1, 16'h091C, 16'h0, 16'h0);
      8'd49:  e = mk("jha",  3'd3, 2'd1, 16'h091D, 16'h0, 16'h0);
      8'd50:  e = mk("jh",   3'd2, 2'd1, 16'h091D, 16'h0, 16'h0);
      8'd51:  e = mk("~na",  3'd3, 2'd1, 16'h091E, 16'h0, 16'h0);
      8'd52:  e = mk("~n",   3'd2, 2'd1, 16'h091E, 16'h0, 16'h0);
      8'd53:  e = mk("Ta",   3'd2, 2'd1, 16'h091F, 16'h0, 16'h0);
      8'd54:  e = mk("T",    3'd1, 2'd1, 16'h091F, 16'h0, 16'h0);
      8'd55:  e = mk("Tha",  3'd3, 2'd1, 16'h0920, 16'h0, 16'h0);
      8'd56:  e = mk("Th",   3'd2, 2'd1, 16'h0920, 16'h0, 16'h0);
      8'd57:  e = mk("Da",   3'd2, 2'd1, 16'h0921, 16'h0, 16'h0);
      8'd58:  e = mk("D",    3'd1, 2'd1, 16'h0921, 16'h0, 16'h0);
      8'd59:  e = mk("Dha",  3'd3, 2'd1, 16'h0922, 16'h0, 16'h0);
      8'd60:  e = mk("Dh",   3'd2, 2'd1, 16'h0922, 16'h0, 16'h0);
      8'd61:  e = mk("Na",   3'd2, 2'd1, 16'h0923, 16'h0, 16'h0);
      8'd62:  e = mk("N",    3'd1, 2'd1, 16'h0923, 16'h0, 16'h0);
      8'd63:  e = mk("ta",   3'd2, 2'd1, 16'h0924, 16'h0, 16'h0);
      8'd64:  e = mk("t",    3'd1, 2'd1, 16'h0924, 16'h0, 16'h0);
      8'd65:  e = mk("tha",  3'd3, 2'd1, 16'h0925, 16'h0, 16'h0);
      8'd66:  e = mk("th",   3'd2, 2'd1, 16'h0925, 16'h0, 16'h0);
      8'd67:  e = mk("da",   3'd2, 2'd1, 16'h0926, 16'h0, 16'h0);
      8'd68:  e = mk("d",    3'd1, 2'd1, 16'h0926, 16'h0, 16'h0);
      8'd69:  e = mk("dha",  3'd3, 2'd1, 16'h0927, 16'h0, 16'h0);
      8'd70:  e = mk("dh",   3'd2, 2'd1, 16'h0927, 16'h0, 16'h0);
      8'd71:  e = mk("na",   3'd2, 2'd1, 16'h0928, 16'h0, 16'h0);
      8'd72:  e = mk("n",    3'd1, 2'd1, 16'h0928, 16'h0, 16'h0);
      8'd73:  e = mk("pa",   3'd2, 2'd1, 16'h092A, 16'h0, 16'h0);
      8'd74:  e = mk("p",    3'd1, 2'd1, 16'h092A, 16'h0, 16'h0);
      8'd75:  e = mk("pha",  3'd3, 2'd1, 16'h092B, 16'h0, 16'h0);
      8'd76:  e = mk("ph",   3'd2, 2'd1, 16'h092B, 16'h0, 16'h0);
      8'd77:  e = mk("ba",   3'd2, 2'd1, 16'h092C, 16'h0, 16'h0);
      8'd78:  e = mk("b",    3'd1, 2'd1, 16'h092C, 16'h0, 16'h0);
      8'd79:  e = mk("bha",  3'd3, 2'd1, 16'h092D, 16'h0, 16'h0);
      8'd80:  e = mk("bh",   3'd2, 2'd1, 16'h092D, 16'h0, 16'h0);
      8'd81:  e = mk("ma",   3'd2, 2'd1, 16'h092E, 16'h0, 16'h0);
      8'd82:  e = mk("m",    3'd1, 2'd1, 16'h092E, 16'h0, 16'h0);
      8'd83:  e = mk("ya",   3'd2, 2'd1, 16'h092F, 16'h0, 16'h0);
      8'd84:  e = mk("y",    3'd1, 2'd1, 16'h092F, 16'h0, 16'h0);
      8'd85:  e = mk("ra",   3'd2, 2'd1, 16'h0930, 16'h0, 16'h0);
      8'd86:  e = mk("r",    3'd1, 2'd1, 16'h0930, 16'h0, 16'h0);
      8'd87:  e = mk("la",   3'd2, 2'd1, 16'h0932, 16'h0, 16'h0);
      8'd88:  e = mk("l",    3'd1, 2'd1, 16'h0932, 16'h0, 16'h0);
      8'd89:  e = mk("va",   3'd2, 2'd1, 16'h0935, 16'h0, 16'h0);
      8'd90:  e = mk("v",    3'd1, 2'd1, 16'h0935, 16'h0, 16'h0);
      8'd91:  e = mk("sha",  3'd3, 2'd1, 16'h0936, 16'h0, 16'h0);
      8'd92:  e = mk("sh",   3'd2, 2'd1, 16'h0936, 16'h0, 16'h0);
      8'd93:  e = mk("Sha",  3'd3, 2'd1, 16'h0937, 16'h0, 16'h0);
      8'd94:  e = mk("Sh",   3'd2, 2'd1, 16'h0937, 16'h0, 16'h0);
      8'd95:  e = mk("sa",   3'd2, 2'd1, 16'h0938, 16'h0, 16'h0);
      8'd96:  e = mk("s",    3'd1, 2'd1, 16'h0938, 16'h0, 16'h0);
      8'd97:  e = mk("ha",   3'd2, 2'd1, 16'h0939, 16'h0, 16'h0);
      8'd98:  e = mk("h",    3'd1, 2'd1, 16'h0939, 16'h0, 16'h0);
      8'd99:  e = mk("La",   3'd2, 2'd1, 16'h0933, 16'h0, 16'h0);
      8'd100: e = mk("L",    3'd1, 2'd1, 16'h0933, 16'h0, 16'h0);
      8'd101: e = mk("qa",   3'd2, 2'd1, 16'h0958, 16'h0, 16'h0);
      8'd102: e = mk("q",    3'd1, 2'd1, 16'h0958, 16'h0, 16'h0);
      8'd103: e = mk("Ka",   3'd2, 2'd1, 16'h0959, 16'h0, 16'h0);
      8'd104: e = mk("K",    3'd1, 2'd1, 16'h0959, 16'h0, 16'h0);
      8'd105: e = mk("Ga",   3'd2, 2'd1, 16'h095A, 16'h0, 16'h0);
      8'd106: e = mk("G",    3'd1, 2'd1, 16'h095A, 16'h0, 16'h0);
      8'd107: e = mk("za",   3'd2, 2'd1, 16'h095B, 16'h0, 16'h0);
      8'd108: e = mk("z",    3'd1, 2'd1, 16'h095B, 16'h0, 16'h0);
      8'd109: e = mk("fa",   3'd2, 2'd1, 16'h095C, 16'h0, 16'h0);
      8'd110: e = mk("f",    3'd1, 2'd1, 16'h095C, 16'h0, 16'h0);
      8'd111: e = mk(".Da",  3'd3, 2'd1, 16'h095D, 16'h0, 16'h0);
      8'd112: e = mk(".D",   3'd2, 2'd1, 16'h095D, 16'h0, 16'h0);
      8'd113: e = mk("Ra",   3'd2, 2'd1, 16'h095D, 16'h0, 16'h0);
      8'd114: e = mk("R",    3'd1, 2'd1, 16'h095D, 16'h0, 16'h0);
      8'd115: e = mk(".Dha", 3'd4, 2'd1, 16'h095E, 16'h0, 16'h0);
      8'd116: e = mk(".Dh",  3'd3, 2'd1, 16'h095E, 16'h0, 16'h0);
      8'd117: e = mk("Rha",  3'd3, 2'd1, 16'h095E, 16'h0, 16'h0);
      8'd118: e = mk("Rh",   3'd2, 2'd1, 16'h095E, 16'h0, 16'h0);
      8'd119: e = mk("wa",   3'd2, 2'd2, 16'h0935, 16'h093C, 16'h0);
      8'd120: e = mk("w",    3'd1, 2'd2, 16'h0935, 16'h093C, 16'h0);
      8'd121: e = mk("kSa",  3'd3, 2'd3, 16'h0915, 16'h094D, 16'h0937);
      8'd122: e = mk("kSha", 3'd4, 2'd3, 16'h0915, 16'h094D, 16'h0937);
      8'd123: e = mk("xa",   3'd2, 2'd3, 16'h0915, 16'h094D, 16'h0937);
      8'd124: e = mk("tra",  3'd3, 2'd3, 16'h0924, 16'h094D, 16'h0930);
      8'd125: e = mk("tr",   3'd2, 2'd3, 16'h0924, 16'h094D, 16'h0930);
      8'd126: e = mk("GYa",  3'd3, 2'd3, 16'h091C, 16'h094D, 16'h091E);
      8'd127: e = mk("j~na", 3'd4, 2'd3, 16'h091C, 16'h094D, 16'h091E);
      8'd128: e = mk("shra", 3'd4, 2'd3, 16'h0936, 16'h094D, 16'h0930);
      8'd129: e = mk("i",    3'd1, 2'd1, 16'h093F, 16'h0, 16'h0);
      8'd130: e = mk("I",    3'd1, 2'd1, 16'h0940, 16'h0, 16'h0);
      8'd131: e = mk("ii",   3'd2, 2'd1, 16'h0940, 16'h0, 16'h0);
      8'd132: e = mk("ee",   3'd2, 2'd1, 16'h0940, 16'h0, 16'h0);
      8'd133: e = mk("u",    3'd1, 2'd1, 16'h0941, 16'h0, 16'h0);
      8'd134: e = mk("U",    3'd1, 2'd1, 16'h0942, 16'h0, 16'h0);
      8'd135: e = mk("uu",   3'd2, 2'd1, 16'h0942, 16'h0, 16'h0);
      8'd136: e = mk("RRi",  3'd3, 2'd1, 16'h0943, 16'h0, 16'h0);
      8'd137: e = mk("R^i",  3'd3, 2'd1, 16'h0943, 16'h0, 16'h0);
      8'd138: e = mk("LLi",  3'd3, 2'd1, 16'h0962, 16'h0, 16'h0);
      8'd139: e = mk("L^i",  3'd3, 2'd1, 16'h0962, 16'h0, 16'h0);
      8'd140: e = mk("e",    3'd1, 2'd1, 16'h0947, 16'h0, 16'h0);
      8'd141: e = mk("E",    3'd1, 2'd1, 16'h0947, 16'h0, 16'h0);
      8'd142: e = mk("ai",   3'd2, 2'd1, 16'h0948, 16'h0, 16'h0);
      8'd143: e = mk("o",    3'd1, 2'd1, 16'h094B, 16'h0, 16'h0);
      8'd144: e = mk("O",    3'd1, 2'd1, 16'h094B, 16'h0, 16'h0);
      8'd145: e = mk("au",   3'd2, 2'd1, 16'h094C, 16'h0, 16'h0);
      8'd146: e = mk("M",    3'd1, 2'd1, 16'h0902, 16'h0, 16'h0);
      8'd147: e = mk(".m",   3'd2, 2'd1, 16'h0902, 16'h0, 16'h0);
      8'd148: e = mk(".n",   3'd2, 2'd1, 16'h0902, 16'h0, 16'h0);
      8'd149: e = mk("H",    3'd1, 2'd1, 16'h0903, 16'h0, 16'h0);
      8'd150: e = mk(".N",   3'd2, 2'd1, 16'h0901, 16'h0, 16'h0);
      8'd151: e = mk(".h",   3'd2, 2'd1, 16'h094D, 16'h0, 16'h0);
      8'd152: e = mk(".c",   3'd2, 2'd1, 16'h0945, 16'h0, 16'h0);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: sv/itd_ctrl.sv
// Controller state machine for the transliteration block.
// Depends on itd_pkg for the command and status structs.
`default_nettype none

module itd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              text_valid,
  output logic                   text_stall,
  input  itd_pkg::itd_stat_t     stat,
  output itd_pkg::itd_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_EMIT
  } state_t;

  state_t state;
  logic   stall;
  logic   accept;

  assign text_stall = stall;
  assign accept     = text_valid && !stall;

  // Commands follow the current state and datapath status.
  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.start  = (state == S_CHECK);
    cmd.search = (state == S_SEARCH);
    cmd.emit   = (state == S_EMIT) && stat.slot_free;
  end

  // State and the registered input stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stall <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CHECK;
            stall <= 1'b1;
          end
        end
        S_CHECK: begin
          if (stat.go) begin
            state <= S_SEARCH;
          end else begin
            state <= S_IDLE;
            stall <= 1'b0;
          end
        end
        S_SEARCH: begin
          if (stat.found) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (stat.slot_free && stat.match_last) begin
            state <= S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
          stall <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTH
  // An accepted beat always leads to a window check next cycle.
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CHECK))
    else $error("accepted beat did not reach the check state");

  // Input is held off whenever the controller is busy.
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> stall)
    else $error("input not stalled while busy");

  // Bytes are only sent from the emit state.
  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (state == S_EMIT))
    else $error("emit outside emit state");
`endif

endmodule

`default_nettype wire

FILE: sv/itd_dp.sv
// Datapath: pending window, key ROM search, UTF-8 byte builder and the
// output register. Depends on itd_pkg for structs and the key ROM.
`default_nettype none

module itd_dp #(
  parameter int MAX_KEY_LEN   = 4,
  parameter int TABLE_ENTRIES = 153
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  itd_pkg::in_beat_t       text,
  input  itd_pkg::itd_cmd_t       cmd,
  output itd_pkg::itd_stat_t      stat,
  output logic                    utf8_valid,
  input  wire logic               utf8_stall,
  output itd_pkg::out_beat_t      utf8
);

  localparam int IW    = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int CW    = $clog2(MAX_KEY_LEN + 1);
  localparam int LIMIT = (TABLE_ENTRIES < itd_pkg::ROM_SIZE) ? TABLE_ENTRIES
                                                             : itd_pkg::ROM_SIZE;

  logic [7:0]  win [MAX_KEY_LEN];
  logic [CW-1:0] cnt;
  logic [CW-1:0] len;
  logic [CW-1:0] used;
  logic          end_flag;
  logic          pass;
  logic [15:0]   c0, c1, c2;
  logic [1:0]    ncodes;
  logic [1:0]    k;
  logic [1:0]    b;
  logic          out_v;
  itd_pkg::out_beat_t out_r;

  logic [IW-1:0] pos;
  logic          hit;
  logic [7:0]    hit_idx;
  logic          eq;
  itd_pkg::rom_entry_t ent;
  itd_pkg::rom_entry_t hit_ent;
  logic [15:0]   cur;
  logic [1:0]    nb;
  logic [7:0]    byte_val;
  logic          code_last;
  logic          match_last;
  logic [CW-1:0] rem;
  logic          done;

  assign utf8_valid = out_v;
  assign utf8       = out_r;

  // Write position for a new byte; the window never overflows.
  assign pos = (cnt >= CW'(MAX_KEY_LEN)) ? IW'(MAX_KEY_LEN - 1) : cnt[IW-1:0];

  // Parallel compare of the first TABLE_ENTRIES ROM keys at the current length; first wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    eq      = 1'b0;
    ent     = '0;
    for (int e = LIMIT - 1; e >= 0; e--) begin
      ent = itd_pkg::rom_get(8'(e));
      eq  = (int'(ent.klen) == int'(len));
      for (int j = 0; j < 4; j++) begin
        if (j < MAX_KEY_LEN && j < int'(ent.klen)) begin
          if (ent.key[8 * (int'(ent.klen) - 1 - j) +: 8] != win[IW'(j)]) begin
            eq = 1'b0;
          end
        end
      end
      if (eq) begin
        hit     = 1'b1;
        hit_idx = 8'(e);
      end
    end
  end

  assign hit_ent = itd_pkg::rom_get(hit_idx);

  // UTF-8 byte for the current code point and byte position.
  always_comb begin
    case (k)
      2'd0:    cur = c0;
      2'd1:    cur = c1;
      default: cur = c2;
    endcase
    if (cur <= 16'h007F) begin
      nb = 2'd1;
    end else if (cur <= 16'h07FF) begin
      nb = 2'd2;
    end else begin
      nb = 2'd3;
    end
    byte_val = cur[7:0];
    if (nb == 2'd2) begin
      byte_val = (b == 2'd0) ? {3'b110, cur[10:6]} : {2'b10, cur[5:0]};
    end else if (nb == 2'd3) begin
      case (b)
        2'd0:    byte_val = {4'b1110, cur[15:12]};
        2'd1:    byte_val = {2'b10, cur[11:6]};
        default: byte_val = {2'b10, cur[5:0]};
      endcase
    end
    if (pass) begin
      byte_val = win[0];
    end
  end

  assign code_last  = (b == nb - 2'd1);
  assign match_last = pass || (code_last && (k == ncodes - 2'd1));
  assign rem        = cnt - used;
  assign done       = (rem == '0) || !end_flag;

  always_comb begin
    stat            = '0;
    stat.go         = (cnt != '0) && ((cnt >= CW'(MAX_KEY_LEN)) || end_flag);
    stat.found      = hit || (len == CW'(1));
    stat.slot_free  = !out_v || !utf8_stall;
    stat.match_last = match_last;
  end

  // Window and byte count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= CW'(pos) + CW'(1);
    end else if (cmd.emit && match_last) begin
      cnt <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win[pos] <= text.in_char;
      end_flag <= text.string_end;
    end else if (cmd.emit && match_last) begin
      for (int i = 0; i < MAX_KEY_LEN; i++) begin
        if (i + int'(used) < MAX_KEY_LEN) begin
          win[i] <= win[IW'(i + int'(used))];
        end
      end
    end
  end

  // Length search and match latch.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      len <= cnt;
    end else if (cmd.search) begin
      if (hit) begin
        c0     <= hit_ent.c0;
        c1     <= hit_ent.c1;
        c2     <= hit_ent.c2;
        ncodes <= hit_ent.ncodes;
        used   <= len;
        pass   <= 1'b0;
        k      <= 2'd0;
        b      <= 2'd0;
      end else if (len == CW'(1)) begin
        used   <= CW'(1);
        pass   <= 1'b1;
        k      <= 2'd0;
        b      <= 2'd0;
      end else begin
        len <= len - CW'(1);
      end
    end else if (cmd.emit && !match_last) begin
      if (code_last) begin
        k <= k + 2'd1;
        b <= 2'd0;
      end else begin
        b <= b + 2'd1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (cmd.emit) begin
      out_v <= 1'b1;
    end else if (!utf8_stall) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.out_byte    <= byte_val;
      out_r.run_last    <= match_last && done;
      out_r.string_last <= match_last && done && end_flag;
    end
  end

`ifndef SYNTH
  // The pending count stays within the window.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_KEY_LEN))
    else $error("pending count beyond window");

  // A byte is only loaded when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_v || !utf8_stall))
    else $error("output register overwritten");

  // A new input beat only arrives when the window has room.
  a_load_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (cnt < CW'(MAX_KEY_LEN)))
    else $error("input beat loaded into a full window");
`endif

endmodule

`default_nettype wire

FILE: sv/itrans_to_devanagari_utf8.sv
// Sequence: an input beat is taken in the idle state and checked the next
// cycle; a beat that completes no match returns the block to idle. Each
// match tries key lengths from the longest down, one length per cycle
// against the first TABLE_ENTRIES ROM keys, sends 1 to 9 output bytes
// (held by output stalls) and rechecks the window. One input beat at a time.
// Reset: synchronous, active high; clears the byte count and output valid.
`default_nettype none

module itrans_to_devanagari_utf8 #(
  parameter int MAX_KEY_LEN   = 4,
  parameter int TABLE_ENTRIES = 153
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              text_valid,
  output logic                   text_stall,
  input  itd_pkg::in_beat_t      text,
  output logic                   utf8_valid,
  input  wire logic              utf8_stall,
  output itd_pkg::out_beat_t     utf8
);

  itd_pkg::itd_cmd_t  cmd;
  itd_pkg::itd_stat_t stat;

  // Sequencing of load, search and emit.
  itd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Window, key search and UTF-8 output.
  itd_dp #(
    .MAX_KEY_LEN   (MAX_KEY_LEN),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .cmd        (cmd),
    .stat       (stat),
    .utf8_valid (utf8_valid),
    .utf8_stall (utf8_stall),
    .utf8       (utf8)
  );

endmodule

`default_nettype wire
